// ===== hdl/fcc3_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc3_pkg
// Shared widths, register map and types for the three-point fast cyclic
// convolution block.
// ----------------------------------------------------------------------------
package fcc3_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TAP_W        = SAMPLE_WIDTH;
    localparam int SUM2_W       = SAMPLE_WIDTH + 1;
    localparam int SUM3_W       = SAMPLE_WIDTH + 2;
    localparam int RES_W        = 2 * SAMPLE_WIDTH + 1;

    localparam int NUM_REGS     = 6;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = $clog2(NUM_REGS * 4);
    localparam int IDX_W        = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_TAP0       = IDX_W'(0),
        REG_TAP1       = IDX_W'(1),
        REG_TAP2       = IDX_W'(2),
        REG_TAP_SUM01  = IDX_W'(3),
        REG_TAP_SUM12  = IDX_W'(4),
        REG_TAP_SUM012 = IDX_W'(5)
    } reg_idx_t;

    typedef struct packed {
        logic signed [TAP_W-1:0]  tap0;
        logic signed [TAP_W-1:0]  tap1;
        logic signed [TAP_W-1:0]  tap2;
        logic signed [SUM2_W-1:0] tap_sum01;
        logic signed [SUM2_W-1:0] tap_sum12;
        logic signed [SUM3_W-1:0] tap_sum012;
    } taps_t;

endpackage

// ===== hdl/fcc3_pipe.sv =====
// ----------------------------------------------------------------------------
// fcc3_pipe
// Four-stage datapath: input pre-adds, six multipliers, pairwise
// differences, and the output register with the final combination.
// ----------------------------------------------------------------------------
module fcc3_pipe (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  fcc3_pkg::taps_t                           taps,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [fcc3_pkg::SAMPLE_WIDTH-1:0]  s_sample0,
    input  logic signed [fcc3_pkg::SAMPLE_WIDTH-1:0]  s_sample1,
    input  logic signed [fcc3_pkg::SAMPLE_WIDTH-1:0]  s_sample2,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic        [fcc3_pkg::RES_W-1:0]         m_result0,
    output logic        [fcc3_pkg::RES_W-1:0]         m_result1,
    output logic        [fcc3_pkg::RES_W-1:0]         m_result2
);

    localparam int W  = fcc3_pkg::SAMPLE_WIDTH;
    localparam int RW = fcc3_pkg::RES_W;

    // Stage valids and the ready each stage offers to the one before it.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: samples and their sums.
    logic signed [W-1:0] x0_reg, x1_reg, x2_reg;
    logic signed [W:0]   x01_reg, x12_reg;
    logic signed [W+1:0] x012_reg;
    logic signed [W:0]   x01_next, x12_next;
    logic signed [W+1:0] x012_next;

    // Stage 2: products, kept modulo 2^RW since the results wrap there.
    logic signed [2*W-1:0] m00, m11, m22;
    logic signed [2*W+1:0] m01, m12;
    logic signed [2*W+3:0] m012;
    logic [RW-1:0] p00_reg, p11_reg, p22_reg, p01_reg, p12_reg, p012_reg;
    logic [RW-1:0] p00_next, p11_next, p22_next, p01_next, p12_next, p012_next;

    // Stage 3: pairwise differences.
    logic [RW-1:0] pa_reg, pb_reg, d_reg, q012_reg;
    logic [RW-1:0] pa_next, pb_next, d_next;

    // Stage 4: output words.
    logic [RW-1:0] r0_reg, r1_reg, r2_reg;
    logic [RW-1:0] r0_next, r1_next, r2_next;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_comb begin
        x01_next  = {s_sample0[W-1], s_sample0} + {s_sample1[W-1], s_sample1};
        x12_next  = {s_sample1[W-1], s_sample1} + {s_sample2[W-1], s_sample2};
        x012_next = {x01_next[W], x01_next} + {{2{s_sample2[W-1]}}, s_sample2};
    end

    assign m00  = x0_reg * taps.tap0;
    assign m11  = x1_reg * taps.tap1;
    assign m22  = x2_reg * taps.tap2;
    assign m01  = x01_reg * taps.tap_sum01;
    assign m12  = x12_reg * taps.tap_sum12;
    assign m012 = x012_reg * taps.tap_sum012;

    always_comb begin
        p00_next  = {m00[2*W-1], m00};
        p11_next  = {m11[2*W-1], m11};
        p22_next  = {m22[2*W-1], m22};
        p01_next  = m01[RW-1:0];
        p12_next  = m12[RW-1:0];
        p012_next = m012[RW-1:0];
    end

    always_comb begin
        pa_next = p01_reg - p11_reg;
        pb_next = p12_reg - p11_reg;
        d_next  = p00_reg - p22_reg;
    end

    always_comb begin
        r0_next = pb_reg + d_reg;
        r1_next = pa_reg - d_reg;
        r2_next = q012_reg - pa_reg - pb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            x0_reg   <= s_sample0;
            x1_reg   <= s_sample1;
            x2_reg   <= s_sample2;
            x01_reg  <= x01_next;
            x12_reg  <= x12_next;
            x012_reg <= x012_next;
        end
        if (rdy2 && v1_reg) begin
            p00_reg  <= p00_next;
            p11_reg  <= p11_next;
            p22_reg  <= p22_next;
            p01_reg  <= p01_next;
            p12_reg  <= p12_next;
            p012_reg <= p012_next;
        end
        if (rdy3 && v2_reg) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            d_reg    <= d_next;
            q012_reg <= p012_reg;
        end
        if (rdy4 && v3_reg) begin
            r0_reg <= r0_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
    end

    assign m_valid   = v4_reg;
    assign m_result0 = r0_reg;
    assign m_result1 = r1_reg;
    assign m_result2 = r2_reg;

    // A word taken at the input always lands in the first stage.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word did not reach stage 1");

    // An empty first stage never refuses a word.
    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("input stalled with stage 1 empty");

    // A word in stage 1 that may advance is not dropped.
    a_stage2_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && rdy2 |=> v2_reg)
        else $error("word lost between stage 1 and stage 2");

    // Output words 0 and 2 are the combination of the stage 3 terms.
    a_result_math: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && rdy4 |=> v4_reg
            && r0_reg == $past(pb_reg + d_reg)
            && r2_reg == $past(q012_reg - pa_reg - pb_reg))
        else $error("output word does not match stage 3 terms");

endmodule

// ===== hdl/fast_cyclic_convolution_3pt_top.sv =====
// An accepted input word passes the pre-add, multiply, difference and output registers before m_valid of its result.
// Throughput: one word per cycle while m_ready does not stall the output; the six multipliers sit in their own stage.
// A stall at m_ready holds the pipeline; empty stages still take new words.
// Reset (aresetn low at a clock edge) clears all taps to zero and empties
// the pipeline.
// ----------------------------------------------------------------------------
// fast_cyclic_convolution_3pt_top
// Three-point cyclic convolution with six multiplications; kernel taps and
// their precomputed sums are loaded through an APB register port.
// ----------------------------------------------------------------------------
module fast_cyclic_convolution_3pt_top (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic        [fcc3_pkg::ADDR_W-1:0]        paddr,
    input  logic        [fcc3_pkg::DATA_W-1:0]        pwdata,
    output logic        [fcc3_pkg::DATA_W-1:0]        prdata,
    output logic                                      pready,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [fcc3_pkg::SAMPLE_WIDTH-1:0]  s_sample0,
    input  logic signed [fcc3_pkg::SAMPLE_WIDTH-1:0]  s_sample1,
    input  logic signed [fcc3_pkg::SAMPLE_WIDTH-1:0]  s_sample2,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [fcc3_pkg::RES_W-1:0]         m_result0,
    output logic signed [fcc3_pkg::RES_W-1:0]         m_result1,
    output logic signed [fcc3_pkg::RES_W-1:0]         m_result2
);

    localparam int TW = fcc3_pkg::TAP_W;
    localparam int S2 = fcc3_pkg::SUM2_W;
    localparam int S3 = fcc3_pkg::SUM3_W;
    localparam int DW = fcc3_pkg::DATA_W;

    fcc3_pkg::taps_t    taps_reg;
    fcc3_pkg::reg_idx_t reg_idx;
    logic               wr_en;
    logic [fcc3_pkg::RES_W-1:0] res0, res1, res2;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = fcc3_pkg::reg_idx_t'(paddr[fcc3_pkg::ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                fcc3_pkg::REG_TAP0:       taps_reg.tap0       <= pwdata[TW-1:0];
                fcc3_pkg::REG_TAP1:       taps_reg.tap1       <= pwdata[TW-1:0];
                fcc3_pkg::REG_TAP2:       taps_reg.tap2       <= pwdata[TW-1:0];
                fcc3_pkg::REG_TAP_SUM01:  taps_reg.tap_sum01  <= pwdata[S2-1:0];
                fcc3_pkg::REG_TAP_SUM12:  taps_reg.tap_sum12  <= pwdata[S2-1:0];
                fcc3_pkg::REG_TAP_SUM012: taps_reg.tap_sum012 <= pwdata[S3-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the tap sign-extended to the bus width; unmapped addresses read as zero.
    always_comb begin
        unique case (reg_idx)
            fcc3_pkg::REG_TAP0:
                prdata = {{(DW-TW){taps_reg.tap0[TW-1]}}, taps_reg.tap0};
            fcc3_pkg::REG_TAP1:
                prdata = {{(DW-TW){taps_reg.tap1[TW-1]}}, taps_reg.tap1};
            fcc3_pkg::REG_TAP2:
                prdata = {{(DW-TW){taps_reg.tap2[TW-1]}}, taps_reg.tap2};
            fcc3_pkg::REG_TAP_SUM01:
                prdata = {{(DW-S2){taps_reg.tap_sum01[S2-1]}}, taps_reg.tap_sum01};
            fcc3_pkg::REG_TAP_SUM12:
                prdata = {{(DW-S2){taps_reg.tap_sum12[S2-1]}}, taps_reg.tap_sum12};
            fcc3_pkg::REG_TAP_SUM012:
                prdata = {{(DW-S3){taps_reg.tap_sum012[S3-1]}}, taps_reg.tap_sum012};
            default:
                prdata = '0;
        endcase
    end

    fcc3_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .taps      (taps_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample0 (s_sample0),
        .s_sample1 (s_sample1),
        .s_sample2 (s_sample2),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result0 (res0),
        .m_result1 (res1),
        .m_result2 (res2)
    );

    assign m_result0 = $signed(res0);
    assign m_result1 = $signed(res1);
    assign m_result2 = $signed(res2);

endmodule
